/* rtl/hecc_pkg.sv */
`default_nettype none

package hecc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned EccW      = 24;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned BitIdxW   = 3;
  localparam int unsigned ColW      = 6;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 40;

  localparam logic [ByteW-1:0] LastByteIdx = 8'hFF;

  // Operation selector carried in the slave-side tuser.
  localparam logic OpData  = 1'b0;
  localparam logic OpCheck = 1'b1;

  // Result kind carried in the master-side tuser.
  localparam logic KindGen   = 1'b0;
  localparam logic KindCheck = 1'b1;

  localparam logic [StatusW-1:0] StNone    = 2'd0;
  localparam logic [StatusW-1:0] StDataBit = 2'd1;
  localparam logic [StatusW-1:0] StEccBit  = 2'd2;
  localparam logic [StatusW-1:0] StUncorr  = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   byte_addr;
    logic [BitIdxW-1:0] bit_idx;
  } chk_res_t;

  // Column parities CP0..CP5 of one byte.
  function automatic logic [ColW-1:0] column_bits(input logic [ByteW-1:0] b);
    logic [ColW-1:0] c;
    c[0] = ^(b & 8'h55);
    c[1] = ^(b & 8'hAA);
    c[2] = ^(b & 8'h33);
    c[3] = ^(b & 8'hCC);
    c[4] = ^(b & 8'h0F);
    c[5] = ^(b & 8'hF0);
    return c;
  endfunction

  // Builds the inverted three-byte code from the accumulated parities.
  function automatic logic [EccW-1:0] form_ecc(input logic [ByteW-1:0] line_idx,
                                               input logic             odd_cnt,
                                               input logic [ColW-1:0]  col);
    logic [ByteW-1:0] even_lp;
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    even_lp = odd_cnt ? ~line_idx : line_idx;
    for (int k = 0; k < 4; k++) begin
      hi[7-2*k] = line_idx[7-k];
      hi[6-2*k] = even_lp[7-k];
      lo[7-2*k] = line_idx[3-k];
      lo[6-2*k] = even_lp[3-k];
    end
    return {~hi, ~lo, ~col, 2'b11};
  endfunction

endpackage

`default_nettype wire

/* rtl/nand_hamming_ecc_engine.sv */
// Hamming ECC engine for 256-byte NAND blocks in the SmartMedia code layout.
// Slave stream: tuser selects the operation (0 data byte, 1 check). A data
// beat carries one byte of the block in tdata[7:0]; a check beat carries the
// three ECC bytes read from flash in tdata[31:8], byte0 uppermost.
// Master stream: one beat after the 256th byte of a block (tuser 0, the new
// code) and one beat for every check (tuser 1, status with the failing byte
// address and bit position when a single data bit is in error).
// Bytes 1 to 255 of a block produce no output beat.
// An accepted beat is registered in the input register, and its result is
// then registered in the output register, from which it is offered.
// Throughput is one beat per cycle while the output register is free or the
// beat produces no result, set by the single input register feeding the
// output register through the parity logic.
// When the receiver stalls, the output register holds its beat and one more
// beat waits in the input register; further beats are then refused. Data
// bytes that produce no result keep flowing during a stall.
// Reset clears the byte counter, the accumulators and the latched code (so a
// check before the first full block compares against zero) and empties both
// registers.
`default_nettype none

module nand_hamming_ecc_engine (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: data_byte [7:0], flash_ecc [31:8]
  input  wire logic [hecc_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: operation
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata: computed_ecc [23:0], check_status [25:24], error_byte_address [33:26],
  //        error_bit_index [36:34], zero [39:37]
  output logic [hecc_pkg::OutDataW-1:0]        m_axis_tdata,
  // tuser: result_kind
  output logic                                 m_axis_tuser
);

  logic                            in_vld_q;
  logic                            in_op_q;
  logic [hecc_pkg::ByteW-1:0]      in_byte_q;
  logic [hecc_pkg::EccW-1:0]       in_ecc_q;

  logic                            out_vld_q, out_vld_d;
  logic [hecc_pkg::EccW-1:0]       out_ecc_q, out_ecc_d;
  logic                            out_kind_q, out_kind_d;
  hecc_pkg::chk_res_t              out_res_q, out_res_d;

  logic                            last_byte;
  logic [hecc_pkg::EccW-1:0]       new_ecc;
  logic [hecc_pkg::EccW-1:0]       saved_ecc;
  hecc_pkg::chk_res_t              chk_res;
  logic                            produces;
  logic                            out_free;
  logic                            advance;
  logic                            in_take;

  assign produces = (in_op_q == hecc_pkg::OpCheck) || last_byte;
  assign out_free = !out_vld_q || m_axis_tready;
  assign advance  = in_vld_q && (!produces || out_free);
  assign in_take  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !in_vld_q || advance;

  hecc_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_en_i   (advance && (in_op_q == hecc_pkg::OpData)),
    .data_byte_i (in_byte_q),
    .last_byte_o (last_byte),
    .new_ecc_o   (new_ecc),
    .saved_ecc_o (saved_ecc)
  );

  hecc_chk u_chk (
    .saved_ecc_i (saved_ecc),
    .flash_ecc_i (in_ecc_q),
    .res_o       (chk_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata[7:0];
      in_ecc_q  <= s_axis_tdata[31:8];
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_ecc_d  = out_ecc_q;
    out_kind_d = out_kind_q;
    out_res_d  = out_res_q;
    if (advance && produces) begin
      out_vld_d = 1'b1;
      if (in_op_q == hecc_pkg::OpCheck) begin
        out_ecc_d  = saved_ecc;
        out_kind_d = hecc_pkg::KindCheck;
        out_res_d  = chk_res;
      end else begin
        out_ecc_d  = new_ecc;
        out_kind_d = hecc_pkg::KindGen;
        out_res_d  = '0;
      end
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ecc_q  <= out_ecc_d;
    out_kind_q <= out_kind_d;
    out_res_q  <= out_res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {3'b000, out_res_q.bit_idx, out_res_q.byte_addr,
                          out_res_q.status, out_ecc_q};

endmodule

`default_nettype wire

/* rtl/hecc_gen.sv */
`default_nettype none

module hecc_gen (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        byte_en_i,
  input  wire logic [hecc_pkg::ByteW-1:0]  data_byte_i,
  output logic                             last_byte_o,
  output logic [hecc_pkg::EccW-1:0]        new_ecc_o,
  output logic [hecc_pkg::EccW-1:0]        saved_ecc_o
);

  logic [hecc_pkg::ByteW-1:0] byte_cnt_q, byte_cnt_d;
  logic [hecc_pkg::ColW-1:0]  col_par_q, col_par_d;
  logic [hecc_pkg::ByteW-1:0] line_idx_q, line_idx_d;
  logic                       odd_cnt_q, odd_cnt_d;
  logic [hecc_pkg::EccW-1:0]  saved_ecc_q, saved_ecc_d;
  logic [hecc_pkg::ColW-1:0]  col_acc;
  logic [hecc_pkg::ByteW-1:0] line_acc;
  logic                       odd_acc;
  logic                       byte_odd;

  assign byte_odd    = ^data_byte_i;
  assign col_acc     = col_par_q ^ hecc_pkg::column_bits(data_byte_i);
  assign line_acc    = byte_odd ? (line_idx_q ^ byte_cnt_q) : line_idx_q;
  assign odd_acc     = odd_cnt_q ^ byte_odd;
  assign last_byte_o = (byte_cnt_q == hecc_pkg::LastByteIdx);
  assign new_ecc_o   = hecc_pkg::form_ecc(line_acc, odd_acc, col_acc);
  assign saved_ecc_o = saved_ecc_q;

  always_comb begin
    byte_cnt_d  = byte_cnt_q;
    col_par_d   = col_par_q;
    line_idx_d  = line_idx_q;
    odd_cnt_d   = odd_cnt_q;
    saved_ecc_d = saved_ecc_q;
    if (byte_en_i) begin
      if (last_byte_o) begin
        // The block is complete: latch the code and start the next block afresh.
        saved_ecc_d = new_ecc_o;
        byte_cnt_d  = '0;
        col_par_d   = '0;
        line_idx_d  = '0;
        odd_cnt_d   = 1'b0;
      end else begin
        byte_cnt_d  = byte_cnt_q + hecc_pkg::ByteW'(1);
        col_par_d   = col_acc;
        line_idx_d  = line_acc;
        odd_cnt_d   = odd_acc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q  <= '0;
      col_par_q   <= '0;
      line_idx_q  <= '0;
      odd_cnt_q   <= 1'b0;
      saved_ecc_q <= '0;
    end else begin
      byte_cnt_q  <= byte_cnt_d;
      col_par_q   <= col_par_d;
      line_idx_q  <= line_idx_d;
      odd_cnt_q   <= odd_cnt_d;
      saved_ecc_q <= saved_ecc_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/hecc_chk.sv */
`default_nettype none

module hecc_chk (
  input  wire logic [hecc_pkg::EccW-1:0] saved_ecc_i,
  input  wire logic [hecc_pkg::EccW-1:0] flash_ecc_i,
  output hecc_pkg::chk_res_t             res_o
);

  logic [hecc_pkg::EccW-1:0]  diff;
  logic [hecc_pkg::ByteW-1:0] d1, d2, d3;
  logic                       correctable;
  logic                       single_bit;

  assign diff = saved_ecc_i ^ flash_ecc_i;
  assign d1   = diff[23:16];
  assign d2   = diff[15:8];
  assign d3   = diff[7:0];

  // A single data bit error flips exactly one bit of every parity pair.
  assign correctable = (((d1 ^ (d1 >> 1)) & 8'h55) == 8'h55)
                    && (((d2 ^ (d2 >> 1)) & 8'h55) == 8'h55)
                    && (((d3 ^ (d3 >> 1)) & 8'h54) == 8'h54);
  assign single_bit  = (diff != '0) && ((diff & (diff - hecc_pkg::EccW'(1))) == '0);

  always_comb begin
    res_o = '0;
    priority if (diff == '0) begin
      res_o.status = hecc_pkg::StNone;
    end else if (correctable) begin
      res_o.status = hecc_pkg::StDataBit;
      for (int k = 0; k < 4; k++) begin
        res_o.byte_addr[7-k] = d1[7-2*k];
        res_o.byte_addr[3-k] = d2[7-2*k];
      end
      for (int k = 0; k < 3; k++) begin
        res_o.bit_idx[2-k] = d3[7-2*k];
      end
    end else if (single_bit) begin
      res_o.status = hecc_pkg::StEccBit;
    end else begin
      res_o.status = hecc_pkg::StUncorr;
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hecc_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned PrintLimit = 50;

  typedef struct packed {
    logic [EccW-1:0]    ecc;
    logic               kind;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   addr;
    logic [BitIdxW-1:0] bit_pos;
  } ecc_result_t;

  // How the ECC offered on a check beat relates to the latched one.
  typedef enum int unsigned {
    ReadExact,
    ReadDataFlip,
    ReadEccFlip,
    ReadDoubleFlip,
    ReadNoise
  } read_kind_e;

  typedef enum int unsigned {
    FillRandom,
    FillConstant,
    FillSparse,
    FillExtremes
  } fill_mode_e;

  class EccScoreboard;
    bit [ByteW-1:0] byte_idx;
    bit [ColW-1:0]  col_acc;
    bit [ByteW-1:0] line_acc;
    bit             odd_cnt;
    bit [EccW-1:0]  latched_ecc;
    ecc_result_t    pending_q[$];
    int unsigned    fails;
    int unsigned    results;

    function new();
      byte_idx    = '0;
      col_acc     = '0;
      line_acc    = '0;
      odd_cnt     = 1'b0;
      latched_ecc = '0;
      fails       = 0;
      results     = 0;
    endfunction

    function bit [ColW-1:0] column_parity(bit [ByteW-1:0] b);
      bit [ColW-1:0] cp;
      cp[0] = b[0] ^ b[2] ^ b[4] ^ b[6];
      cp[1] = b[1] ^ b[3] ^ b[5] ^ b[7];
      cp[2] = b[0] ^ b[1] ^ b[4] ^ b[5];
      cp[3] = b[2] ^ b[3] ^ b[6] ^ b[7];
      cp[4] = b[0] ^ b[1] ^ b[2] ^ b[3];
      cp[5] = b[4] ^ b[5] ^ b[6] ^ b[7];
      return cp;
    endfunction

    // Line parity pairs interleave as (odd, even) per address bit, address bit 7 uppermost.
    function bit [EccW-1:0] encode();
      bit [ByteW-1:0]   even_lp;
      bit [2*ByteW-1:0] lines;
      even_lp = line_acc ^ {ByteW{odd_cnt}};
      for (int j = 0; j < ByteW; j++) begin
        lines[2*j+1] = line_acc[j];
        lines[2*j]   = even_lp[j];
      end
      return {~lines, ~col_acc, 2'b11};
    endfunction

    function ecc_result_t classify(bit [EccW-1:0] rd);
      ecc_result_t r;
      bit [EccW-1:0] d;
      bit paired;
      d = latched_ecc ^ rd;
      r = '{ecc: latched_ecc, kind: KindCheck, status: StNone, addr: '0, bit_pos: '0};
      // A single data bit error flips exactly one bit of every parity pair.
      paired = (d[7] ^ d[6]) & (d[5] ^ d[4]) & (d[3] ^ d[2]);
      for (int j = 0; j < ByteW; j++) begin
        paired &= d[9+2*j] ^ d[8+2*j];
      end
      if (d == '0) begin
        r.status = StNone;
      end else if (paired) begin
        r.status = StDataBit;
        for (int j = 0; j < ByteW; j++) begin
          r.addr[j] = d[9+2*j];
        end
        r.bit_pos = {d[7], d[5], d[3]};
      end else if ($countones(d) == 1) begin
        r.status = StEccBit;
      end else begin
        r.status = StUncorr;
      end
      return r;
    endfunction

    function void note_input(bit op, bit [ByteW-1:0] b, bit [EccW-1:0] rd);
      if (op == OpCheck) begin
        pending_q.push_back(classify(rd));
        return;
      end
      col_acc ^= column_parity(b);
      if (^b) begin
        line_acc ^= byte_idx;
        odd_cnt = ~odd_cnt;
      end
      if (byte_idx == LastByteIdx) begin
        latched_ecc = encode();
        pending_q.push_back('{ecc: latched_ecc, kind: KindGen, status: StNone,
                              addr: '0, bit_pos: '0});
        byte_idx = '0;
        col_acc  = '0;
        line_acc = '0;
        odd_cnt  = 1'b0;
      end else begin
        byte_idx++;
      end
    endfunction

    task report(string field, logic [OutDataW-1:0] got, logic [OutDataW-1:0] want);
      fails++;
      if (fails <= PrintLimit) begin
        $display("result beat %0d: %s got 'h%0h, expected 'h%0h", results, field, got, want);
      end
    endtask

    task check_result(logic kind, logic [OutDataW-1:0] data);
      ecc_result_t want;
      results++;
      if (pending_q.size() == 0) begin
        report("beat with nothing outstanding", data, '0);
        return;
      end
      want = pending_q.pop_front();
      if (kind !== want.kind) begin
        report("result_kind", OutDataW'(kind), OutDataW'(want.kind));
      end
      if (data[23:0] !== want.ecc) begin
        report("computed_ecc", OutDataW'(data[23:0]), OutDataW'(want.ecc));
      end
      if (data[25:24] !== want.status) begin
        report("check_status", OutDataW'(data[25:24]), OutDataW'(want.status));
      end
      if (data[33:26] !== want.addr) begin
        report("error_byte_address", OutDataW'(data[33:26]), OutDataW'(want.addr));
      end
      if (data[36:34] !== want.bit_pos) begin
        report("error_bit_index", OutDataW'(data[36:34]), OutDataW'(want.bit_pos));
      end
      if (data[39:37] !== 3'b000) begin
        report("padding", OutDataW'(data[39:37]), '0);
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  EccScoreboard sb;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  cycles = 0;

  nand_hamming_ecc_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  function automatic logic [EccW-1:0] data_bit_syndrome(logic [ByteW-1:0] addr,
                                                        logic [BitIdxW-1:0] pos);
    logic [EccW-1:0] s;
    s = '0;
    for (int j = 0; j < ByteW; j++) begin
      s[9+2*j] = addr[j];
      s[8+2*j] = ~addr[j];
    end
    s[7:2] = {pos[2], ~pos[2], pos[1], ~pos[1], pos[0], ~pos[0]};
    return s;
  endfunction

  function automatic logic [EccW-1:0] flash_ecc_for(read_kind_e how);
    logic [EccW-1:0] flip;
    int unsigned a;
    int unsigned b;
    flip = '0;
    case (how)
      ReadExact: begin
        flip = '0;
      end
      ReadDataFlip: begin
        flip = data_bit_syndrome(ByteW'($urandom_range(0, 255)),
                                 BitIdxW'($urandom_range(0, 7)));
        // The two spare bits of the third byte do not matter to the syndrome.
        if ($urandom_range(0, 3) == 0) flip[1:0] = 2'($urandom_range(1, 3));
      end
      ReadEccFlip: begin
        flip = 24'h1 << $urandom_range(0, EccW - 1);
      end
      ReadDoubleFlip: begin
        a = $urandom_range(0, EccW - 1);
        do b = $urandom_range(0, EccW - 1); while (b == a);
        flip = (24'h1 << a) | (24'h1 << b);
      end
      default: begin
        return EccW'($urandom);
      end
    endcase
    return sb.latched_ecc ^ flip;
  endfunction

  // Called and returns at a falling edge; tvalid stays high only if the next call follows at once.
  task automatic send_beat(logic op, logic [ByteW-1:0] b, logic [EccW-1:0] rd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {rd, b};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, b, rd);
    @(negedge clk_i);
  endtask

  task automatic hold_off();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(int unsigned s_pct, int unsigned r_pct, int unsigned blocks);
    fill_mode_e      mode;
    logic [ByteW-1:0] fill;
    logic [ByteW-1:0] b;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (blocks) begin
      mode = fill_mode_e'($urandom_range(0, 3));
      fill = ByteW'($urandom);
      // Runs until the byte counter wraps, which also finishes a block left partial by noise.
      do begin
        case (mode)
          FillRandom:   b = ByteW'($urandom);
          FillConstant: b = fill;
          FillSparse:   b = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'h00;
          default:      b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        if ($urandom_range(0, 47) == 0) begin
          send_beat(OpCheck, ByteW'($urandom),
                    flash_ecc_for(read_kind_e'($urandom_range(0, 4))));
        end
        send_beat(OpData, b, EccW'($urandom));
      end while (sb.byte_idx != '0);
      for (int k = 0; k < 7; k++) begin
        send_beat(OpCheck, ByteW'($urandom),
                  flash_ecc_for(k < 5 ? read_kind_e'(k) : read_kind_e'($urandom_range(0, 4))));
      end
    end
    repeat (20) begin
      send_beat(1'($urandom_range(0, 1)), ByteW'($urandom),
                flash_ecc_for(read_kind_e'($urandom_range(0, 4))));
    end
    hold_off();
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Checks against the code cleared by reset.
    send_beat(OpCheck, 8'h00, 24'h000000);
    send_beat(OpCheck, 8'hFF, 24'hFFFFFF);
    send_beat(OpCheck, 8'h00, 24'h800000);
    send_beat(OpCheck, 8'h00, 24'h000001);
    send_beat(OpCheck, 8'h00, data_bit_syndrome(8'hFF, 3'd7));
    send_beat(OpCheck, 8'h00, data_bit_syndrome(8'h00, 3'd0) | 24'h000003);
    send_beat(OpCheck, 8'h00, 24'h000003);
    // A few bytes, then a check in the middle of the block.
    send_beat(OpData, 8'h00, 24'hFFFFFF);
    send_beat(OpData, 8'hFF, 24'h000000);
    send_beat(OpData, 8'h01, 24'hFFFFFF);
    send_beat(OpData, 8'h80, 24'h000000);
    send_beat(OpData, 8'hAA, 24'hFFFFFF);
    send_beat(OpData, 8'h55, 24'h000000);
    send_beat(OpData, 8'h0F, 24'hFFFFFF);
    send_beat(OpData, 8'hF0, 24'h000000);
    send_beat(OpCheck, 8'h5A, 24'h000000);
    send_beat(OpData, 8'h3C, 24'hFFFFFF);
    hold_off();

    run_phase(26, 63, 1);
    run_phase(63, 26, 1);
    run_phase(0, 0, 2);

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
